### rtl/core/aabb_affine_transform_defines.svh
// assertion helpers for the box transform pipeline
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

// same-cycle implication, disabled in reset
`define AAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define AAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/aat_pkg.sv
package aat_pkg;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned COEF_FRAC = 8;
  localparam int unsigned AXES      = 3;
  localparam int unsigned ROW_W     = AXES * COEF_W;
  localparam int unsigned PROD_W    = COORD_W + COEF_W;
  localparam int unsigned TERM_W    = PROD_W - COEF_FRAC;
  localparam int unsigned SUM_W     = TERM_W + 2;
  localparam int unsigned LATENCY   = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic        [ROW_W-1:0]   row_t;

  localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_W-1){1'b0}}});

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
    row_t   lin_row_x;
    row_t   lin_row_y;
    row_t   lin_row_z;
    coord_t shift_x;
    coord_t shift_y;
    coord_t shift_z;
  } aabb_in_t;

  typedef struct packed {
    coord_t out_min_x;
    coord_t out_min_y;
    coord_t out_min_z;
    coord_t out_max_x;
    coord_t out_max_y;
    coord_t out_max_z;
  } aabb_out_t;

  typedef struct packed {
    logic [AXES-1:0][AXES-1:0][PROD_W-1:0] p_lo;
    logic [AXES-1:0][AXES-1:0][PROD_W-1:0] p_hi;
    logic [AXES-1:0][COORD_W-1:0]          shift;
  } prod_stage_t;

  typedef struct packed {
    logic [AXES-1:0][AXES-1:0][TERM_W-1:0] t_min;
    logic [AXES-1:0][AXES-1:0][TERM_W-1:0] t_max;
    logic [AXES-1:0][COORD_W-1:0]          shift;
  } term_stage_t;

endpackage

### rtl/core/aabb_affine_transform.sv
// channel    direction  handshake              payload
// command    in         start_i / busy_o       box_i  (aabb_in_t)
// result     out        done_o (one cycle)     box_o  (aabb_out_t)
//
// one transaction per cycle; busy_o never rises
// register stages in order: product, fraction drop and min/max, sum, saturate
// each stage a register bank with a valid bit; results leave on done_o
// rst_ni clears the valid bits only; payload registers are not reset
`include "aabb_affine_transform_defines.svh"

module aabb_affine_transform import aat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  aabb_in_t  box_i,
  output logic      done_o,
  output aabb_out_t box_o
);

  logic        prod_valid;
  prod_stage_t prod_stage;
  logic        term_valid;
  term_stage_t term_stage;
  logic        accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  aat_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .box_i   (box_i),
    .valid_o (prod_valid),
    .stage_o (prod_stage)
  );

  aat_minmax u_minmax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .prod_i  (prod_stage),
    .valid_o (term_valid),
    .stage_o (term_stage)
  );

  aat_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (term_valid),
    .term_i  (term_stage),
    .valid_o (done_o),
    .box_o   (box_o)
  );

  `AAT_ASSERT_IMP(a_done_latency, done_o, $past(start_i, LATENCY), "result without transaction")
  `AAT_ASSERT_IMP(a_box_order, done_o,
    (box_o.out_min_x <= box_o.out_max_x) && (box_o.out_min_y <= box_o.out_max_y) &&
    (box_o.out_min_z <= box_o.out_max_z), "result lower corner above upper corner")
  `AAT_ASSERT_NXT(a_term_flow, prod_valid, term_valid, "term stage lost a transaction")

endmodule

### rtl/core/aat_prod.sv
module aat_prod import aat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  aabb_in_t    box_i,
  output logic        valid_o,
  output prod_stage_t stage_o
);

  coord_t      lo_c [AXES];
  coord_t      hi_c [AXES];
  row_t        rows [AXES];
  coord_t      sh   [AXES];
  prod_stage_t stage_d;
  prod_stage_t stage_q;
  logic        valid_q;

  assign lo_c[0] = box_i.box_min_x;
  assign lo_c[1] = box_i.box_min_y;
  assign lo_c[2] = box_i.box_min_z;
  assign hi_c[0] = box_i.box_max_x;
  assign hi_c[1] = box_i.box_max_y;
  assign hi_c[2] = box_i.box_max_z;
  assign rows[0] = box_i.lin_row_x;
  assign rows[1] = box_i.lin_row_y;
  assign rows[2] = box_i.lin_row_z;
  assign sh[0]   = box_i.shift_x;
  assign sh[1]   = box_i.shift_y;
  assign sh[2]   = box_i.shift_z;

  for (genvar r = 0; r < AXES; r++) begin : g_row
    assign stage_d.shift[r] = sh[r];
    for (genvar k = 0; k < AXES; k++) begin : g_col
      coef_t                    c;
      logic signed [PROD_W-1:0] c_ext;
      logic signed [PROD_W-1:0] lo_ext;
      logic signed [PROD_W-1:0] hi_ext;
      assign c      = coef_t'(rows[r][k*COEF_W +: COEF_W]);
      assign c_ext  = PROD_W'(c);
      assign lo_ext = PROD_W'(lo_c[k]);
      assign hi_ext = PROD_W'(hi_c[k]);
      assign stage_d.p_lo[r][k] = c_ext * lo_ext;
      assign stage_d.p_hi[r][k] = c_ext * hi_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/core/aat_minmax.sv
module aat_minmax import aat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  prod_stage_t prod_i,
  output logic        valid_o,
  output term_stage_t stage_o
);

  term_stage_t stage_d;
  term_stage_t stage_q;
  logic        valid_q;

  // arithmetic shift right drops the coefficient fraction bits
  for (genvar r = 0; r < AXES; r++) begin : g_row
    assign stage_d.shift[r] = prod_i.shift[r];
    for (genvar k = 0; k < AXES; k++) begin : g_col
      logic signed [TERM_W-1:0] p;
      logic signed [TERM_W-1:0] q;
      logic                     p_lt;
      assign p    = prod_i.p_lo[r][k][PROD_W-1:COEF_FRAC];
      assign q    = prod_i.p_hi[r][k][PROD_W-1:COEF_FRAC];
      assign p_lt = p < q;
      assign stage_d.t_min[r][k] = p_lt ? p : q;
      assign stage_d.t_max[r][k] = p_lt ? q : p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/core/aat_sum.sv
module aat_sum import aat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  term_stage_t term_i,
  output logic        valid_o,
  output aabb_out_t   box_o
);

  logic [AXES-1:0][SUM_W-1:0] s_min_d;
  logic [AXES-1:0][SUM_W-1:0] s_max_d;
  logic [AXES-1:0][SUM_W-1:0] s_min_q;
  logic [AXES-1:0][SUM_W-1:0] s_max_q;
  logic                       sum_valid_q;
  coord_t                     c_min [AXES];
  coord_t                     c_max [AXES];
  aabb_out_t                  box_d;
  aabb_out_t                  box_q;
  logic                       out_valid_q;

  function automatic coord_t sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    coord_t                  res;
    hi = SUM_W'(COORD_MAX);
    lo = SUM_W'(COORD_MIN);
    if (v > hi) begin
      res = COORD_MAX;
    end else if (v < lo) begin
      res = COORD_MIN;
    end else begin
      res = coord_t'(v[COORD_W-1:0]);
    end
    return res;
  endfunction

  for (genvar r = 0; r < AXES; r++) begin : g_row
    logic signed [COORD_W-1:0] sh;
    logic signed [TERM_W-1:0]  m0, m1, m2, x0, x1, x2;
    assign sh = term_i.shift[r];
    assign m0 = term_i.t_min[r][0];
    assign m1 = term_i.t_min[r][1];
    assign m2 = term_i.t_min[r][2];
    assign x0 = term_i.t_max[r][0];
    assign x1 = term_i.t_max[r][1];
    assign x2 = term_i.t_max[r][2];
    assign s_min_d[r] = SUM_W'(sh) + SUM_W'(m0) + SUM_W'(m1) + SUM_W'(m2);
    assign s_max_d[r] = SUM_W'(sh) + SUM_W'(x0) + SUM_W'(x1) + SUM_W'(x2);
    assign c_min[r]   = sat(s_min_q[r]);
    assign c_max[r]   = sat(s_max_q[r]);
  end

  assign box_d.out_min_x = c_min[0];
  assign box_d.out_min_y = c_min[1];
  assign box_d.out_min_z = c_min[2];
  assign box_d.out_max_x = c_max[0];
  assign box_d.out_max_y = c_max[1];
  assign box_d.out_max_z = c_max[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= valid_i;
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s_min_q <= s_min_d;
      s_max_q <= s_max_d;
    end
    if (sum_valid_q) begin
      box_q <= box_d;
    end
  end

  assign valid_o = out_valid_q;
  assign box_o   = box_q;

endmodule
